@@ sv/sobel_pkg.sv @@
`default_nettype none
package sobel_pkg;

  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned ChannelBits = 8;
  localparam int unsigned RowLimit    = 4096;
  localparam int unsigned PixBits     = 3 * ChannelBits;
  localparam int unsigned ColBits     = $clog2(MaxWidth);
  localparam int unsigned RowBits     = $clog2(RowLimit);
  localparam int unsigned CfgIdxBits  = 8;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned WidthBits   = 11;
  localparam int unsigned HeightBits  = 13;
  // |gx|,|gy| <= 1020, so gx^2+gy^2 fits in 21 bits
  localparam int unsigned GradBits    = 11;
  localparam int unsigned SqBits      = 21;
  localparam int unsigned MagBits     = 11;

  localparam logic [CfgIdxBits-1:0] RegWidth  = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] RegHeight = CfgIdxBits'(1);

  localparam logic [WidthBits-1:0]  WidthReset  = WidthBits'(640);
  localparam logic [HeightBits-1:0] HeightReset = HeightBits'(480);

  typedef struct packed {
    logic [ChannelBits-1:0] in_blue;
    logic [ChannelBits-1:0] in_green;
    logic [ChannelBits-1:0] in_red;
  } pixel_in_t;

  typedef struct packed {
    logic                   frame_end;
    logic [ChannelBits-1:0] edge_blue;
    logic [ChannelBits-1:0] edge_green;
    logic [ChannelBits-1:0] edge_red;
  } edge_out_t;

  typedef struct packed {
    logic [CfgIdxBits-1:0]  index;
    logic [CfgDataBits-1:0] data;
  } cfg_wr_t;

  // controller -> datapath
  typedef struct packed {
    logic               advance;   // shift the pipe by one item
    logic               take;      // an input item enters stage 0
    logic [ColBits-1:0] col;
    logic               interior;
    logic               last;
  } sobel_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;  // some stage holds an item
  } sobel_sts_t;

endpackage
`default_nettype wire

@@ sv/sobel_ram.sv @@
`default_nettype none
module sobel_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ sv/sobel_isqrt.sv @@
`default_nettype none
// Floor square root clamped to 255, one result bit per stage, fully pipelined.
module sobel_isqrt (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic [sobel_pkg::SqBits-1:0]        val_i,
  output logic      [sobel_pkg::ChannelBits-1:0]   mag_o
);

  localparam int unsigned Steps = sobel_pkg::MagBits;
  localparam int unsigned RemW  = sobel_pkg::SqBits + 2;
  localparam int unsigned RadW  = 2 * Steps;

  // stage boundaries: index 0 is the input, index Steps the final root
  wire [RemW-1:0]               rem_w  [Steps+1];
  wire [sobel_pkg::MagBits-1:0] root_w [Steps+1];
  wire [RadW-1:0]               rad_w  [Steps+1];

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = RadW'(val_i);

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [RemW-1:0]               rem_try;
    logic [RemW-1:0]               trial;
    logic [RemW-1:0]               rem_q;
    logic [sobel_pkg::MagBits-1:0] root_q;
    logic [RadW-1:0]               rad_q;
    always_comb begin
      rem_try = {rem_w[s][RemW-3:0], rad_w[s][RadW-1 -: 2]};
      trial   = RemW'({root_w[s], 2'b01});
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q <= {rad_w[s][RadW-3:0], 2'b00};
        if (rem_try >= trial) begin
          rem_q  <= rem_try - trial;
          root_q <= {root_w[s][sobel_pkg::MagBits-2:0], 1'b1};
        end else begin
          rem_q  <= rem_try;
          root_q <= {root_w[s][sobel_pkg::MagBits-2:0], 1'b0};
        end
      end
    end
    assign rem_w[s+1]  = rem_q;
    assign root_w[s+1] = root_q;
    assign rad_w[s+1]  = rad_q;
  end

  assign mag_o = (root_w[Steps] > sobel_pkg::MagBits'(255)) ?
                 sobel_pkg::ChannelBits'(255) :
                 root_w[Steps][sobel_pkg::ChannelBits-1:0];

endmodule
`default_nettype wire

@@ sv/sobel_datapath.sv @@
`default_nettype none
module sobel_datapath (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire sobel_pkg::sobel_cmd_t   cmd_i,
  input  wire sobel_pkg::pixel_in_t    pix_i,
  output sobel_pkg::sobel_sts_t        sts_o,
  output logic                         res_valid_o,
  output sobel_pkg::edge_out_t         res_o
);

  localparam int unsigned PB = sobel_pkg::PixBits;
  localparam int unsigned CB = sobel_pkg::ChannelBits;
  localparam int unsigned GB = sobel_pkg::GradBits;
  localparam int unsigned SB = sobel_pkg::SqBits;
  // stage0 read, 1 window, 2 gradient, 3 square, then isqrt stages
  localparam int unsigned Lat = 4 + sobel_pkg::MagBits;

  logic [Lat-1:0] vld_q, int_q, last_q;
  logic [PB-1:0]  pix_q;
  logic [sobel_pkg::ColBits-1:0] col_q;
  logic [PB-1:0]  top_rd, mid_rd;
  logic [PB-1:0]  win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.advance) begin
      vld_q <= {vld_q[Lat-2:0], cmd_i.take};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      int_q  <= {int_q[Lat-2:0], cmd_i.interior};
      last_q <= {last_q[Lat-2:0], cmd_i.last};
      pix_q  <= pix_i;
      col_q  <= cmd_i.col;
    end
  end

  // Line stores: read in stage 0, written back in stage 1 at the same column.
  sobel_ram #(.Width(PB), .Depth(sobel_pkg::MaxWidth)) u_upper (
    .clk_i, .we_i(cmd_i.advance && vld_q[0]), .waddr_i(col_q), .wdata_i(mid_rd),
    .re_i(cmd_i.advance && cmd_i.take), .raddr_i(cmd_i.col), .rdata_o(top_rd)
  );
  sobel_ram #(.Width(PB), .Depth(sobel_pkg::MaxWidth)) u_middle (
    .clk_i, .we_i(cmd_i.advance && vld_q[0]), .waddr_i(col_q), .wdata_i(pix_q),
    .re_i(cmd_i.advance && cmd_i.take), .raddr_i(cmd_i.col), .rdata_o(mid_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (cmd_i.advance && vld_q[0]) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= top_rd;
      win_q[5] <= mid_rd;
      win_q[8] <= pix_q;
    end
  end

  wire [CB-1:0] mag [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic signed [GB-1:0] p [9];
    logic signed [GB-1:0] gx_q, gy_q;
    logic signed [2*GB-1:0] sx, sy;
    logic [SB-1:0]        sq_q;
    always_comb begin
      for (int i = 0; i < 9; i++) p[i] = GB'(win_q[i][ch*CB +: CB]);
      sx = gx_q * gx_q;
      sy = gy_q * gy_q;
    end
    always_ff @(posedge clk_i) begin
      if (cmd_i.advance) begin
        gx_q <= (p[2] - p[0]) + ((p[5] - p[3]) <<< 1) + (p[8] - p[6]);
        gy_q <= (p[6] - p[0]) + ((p[7] - p[1]) <<< 1) + (p[8] - p[2]);
        sq_q <= SB'(sx) + SB'(sy);
      end
    end
    sobel_isqrt u_sqrt (
      .clk_i, .en_i(cmd_i.advance), .val_i(sq_q), .mag_o(mag[ch])
    );
  end

  assign sts_o.busy   = |vld_q;
  assign res_valid_o  = vld_q[Lat-1] && int_q[Lat-1];
  assign res_o.edge_red   = mag[0];
  assign res_o.edge_green = mag[1];
  assign res_o.edge_blue  = mag[2];
  assign res_o.frame_end  = last_q[Lat-1];

endmodule
`default_nettype wire

@@ sv/sobel_ctrl.sv @@
`default_nettype none
module sobel_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 out_stall_i,
  input  wire logic                 res_valid_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire sobel_pkg::cfg_wr_t   cfg_i,
  input  wire sobel_pkg::sobel_sts_t sts_i,
  output sobel_pkg::sobel_cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    StRun  = 2'b01,
    StHold = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [sobel_pkg::WidthBits-1:0]  width_q;
  logic [sobel_pkg::HeightBits-1:0] height_q;
  logic [sobel_pkg::ColBits:0]      col_q, w_eff;
  logic [sobel_pkg::RowBits:0]      row_q, h_eff;
  logic take, cfg_we;

  always_comb begin
    w_eff = (width_q < 3) ? (sobel_pkg::ColBits+1)'(3) :
            (width_q > sobel_pkg::MaxWidth) ? (sobel_pkg::ColBits+1)'(sobel_pkg::MaxWidth)
                                             : (sobel_pkg::ColBits+1)'(width_q);
    h_eff = (height_q < 3) ? (sobel_pkg::RowBits+1)'(3) :
            (height_q > sobel_pkg::RowLimit) ? (sobel_pkg::RowBits+1)'(sobel_pkg::RowLimit)
                                              : (sobel_pkg::RowBits+1)'(height_q);
  end

  // The pipe moves unless a finished result is stalled at the output.
  always_comb begin
    state_d = (res_valid_i && out_stall_i) ? StHold : StRun;
    cmd_o.advance = !(res_valid_i && out_stall_i);
  end

  assign in_stall_o  = !cmd_o.advance;
  assign take        = in_valid_i && cmd_o.advance;
  assign cfg_ready_o = !sts_i.busy && !in_valid_i;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign cmd_o.take     = take;
  assign cmd_o.col      = col_q[sobel_pkg::ColBits-1:0];
  assign cmd_o.interior = (row_q >= 2) && (col_q >= 2);
  assign cmd_o.last     = (row_q == h_eff - 1'b1) && (col_q == w_eff - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StRun;
      width_q  <= sobel_pkg::WidthReset;
      height_q <= sobel_pkg::HeightReset;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        if (cfg_i.index == sobel_pkg::RegWidth) begin
          width_q <= cfg_i.data[sobel_pkg::WidthBits-1:0];
          col_q <= '0;
          row_q <= '0;
        end else if (cfg_i.index == sobel_pkg::RegHeight) begin
          height_q <= cfg_i.data[sobel_pkg::HeightBits-1:0];
          col_q <= '0;
          row_q <= '0;
        end
      end else if (take) begin
        if (col_q + 1'b1 >= w_eff) begin
          col_q <= '0;
          row_q <= (row_q + 1'b1 >= h_eff) ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) col_q < w_eff || $past(cfg_we))
    else $error("column past row end");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cfg_we && take))
    else $error("config during item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StHold) |-> $past(res_valid_i && out_stall_i))
    else $error("hold without stall");

endmodule
`default_nettype wire

@@ sv/sobel_edge_magnitude_rgb.sv @@
`default_nettype none
// Sobel edge magnitude over an RGB raster stream, one pixel per item. Pixels
// are accepted one per clock unless a stalled result holds the pipe; the
// result for interior pixel (x,y) follows pixel (x+1,y+1) through the window
// stage, the gradient and square stages and the 11-stage bit-per-stage square
// root. Border pixels give no result. A stalled result freezes the whole pipe.
// Config writes are taken only while the pipe is empty and no item is offered.
module sobel_edge_magnitude_rgb (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire sobel_pkg::pixel_in_t in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output sobel_pkg::edge_out_t      out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire sobel_pkg::cfg_wr_t   cfg_i
);

  sobel_pkg::sobel_cmd_t cmd;
  sobel_pkg::sobel_sts_t sts;

  sobel_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_stall_i,
    .res_valid_i(out_valid_o), .cfg_valid_i, .cfg_ready_o, .cfg_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  sobel_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .pix_i(in_data_i), .sts_o(sts),
    .res_valid_o(out_valid_o), .res_o(out_data_o)
  );

endmodule
`default_nettype wire
